@@ design/rm320_pkg.sv @@
package rm320_pkg;

  localparam int WORD_W = 64;
  localparam int NUM_VALUE_WORDS = 5;
  localparam int NUM_MOD_WORDS = 4;
  localparam int VALUE_W = WORD_W * NUM_VALUE_WORDS;
  localparam int MOD_W = WORD_W * NUM_MOD_WORDS;
  localparam int REDUCTION_SHIFT = 64;
  localparam int NUM_STEPS = REDUCTION_SHIFT + 1;
  localparam int CFG_IDX_W = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [MOD_W-1:0] modulus_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MODULUS_WORD0 = 8'd0;
  localparam cfg_idx_t CFG_MODULUS_WORD1 = 8'd1;
  localparam cfg_idx_t CFG_MODULUS_WORD2 = 8'd2;
  localparam cfg_idx_t CFG_MODULUS_WORD3 = 8'd3;

endpackage

@@ design/rm320_step.sv @@
module rm320_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  rm320_pkg::value_t in_value,
  input  rm320_pkg::value_t divisor,
  output logic            out_valid,
  output rm320_pkg::value_t out_value
);
  import rm320_pkg::*;

  logic   valid_r;
  value_t value_r;
  value_t value_nxt;
  logic [VALUE_W:0] diff;

  always_comb begin
    diff = {1'b0, in_value} - {1'b0, divisor};
    // no borrow means value >= divisor
    if (diff[VALUE_W]) begin
      value_nxt = in_value;
    end else begin
      value_nxt = diff[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_value = value_r;

`ifndef SYNTH
  a_step_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    en && in_valid |=> value_r <= $past(in_value))
    else $error("step result exceeds its input");

  a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(valid_r) && (!valid_r || $stable(value_r)))
    else $error("stage changed while frozen");

  a_step_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    en && in_valid && in_value < (divisor << 1) |=> value_r < $past(divisor))
    else $error("step left value at or above divisor");
`endif

endmodule

@@ design/rm320_out.sv @@
module rm320_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tail_valid,
  input  rm320_pkg::modulus_t tail_data,
  output logic              pipe_en,
  output logic              out_valid,
  input  logic              out_stall,
  output rm320_pkg::modulus_t out_data
);
  import rm320_pkg::*;

  logic     out_valid_r;
  modulus_t out_data_r;
  logic     skid_valid_r;
  modulus_t skid_data_r;
  logic     out_load;

  assign pipe_en  = !skid_valid_r;
  assign out_load = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= tail_valid;
      end
    end else if (tail_valid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else begin
        out_data_r <= tail_data;
      end
    end else if (tail_valid && !skid_valid_r) begin
      skid_data_r <= tail_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output is empty");

  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && tail_valid && !skid_valid_r |=> skid_valid_r)
    else $error("tail item dropped while output stalled");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> !skid_valid_r && out_valid_r)
    else $error("skid item not moved to output");
`endif

endmodule

@@ design/reduce_320_mod_256_shift_subtract_core.sv @@
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_value_word0..4, 64 bits each
// out     | output    | out_valid/out_stall| out_remainder_word0..3, 64 bits each
// cfg     | input     | cfg_valid/cfg_ready| cfg_index (8 bits), cfg_data (64 bits)
//
// one item per cycle while in_stall is low; 65 compare-subtract stages, one
// 320-bit borrow chain each, then the output register
// synchronous reset clears all valid bits and the modulus to zero
// out_stall fills a one-item skid register; in_stall is that register's
// full flag, and the whole pipeline freezes while it is set
// cfg_ready is always high; writes to index 4 and above are dropped
module reduce_320_mod_256_shift_subtract_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rm320_pkg::word_t  in_value_word0,
  input  rm320_pkg::word_t  in_value_word1,
  input  rm320_pkg::word_t  in_value_word2,
  input  rm320_pkg::word_t  in_value_word3,
  input  rm320_pkg::word_t  in_value_word4,
  output logic              out_valid,
  input  logic              out_stall,
  output rm320_pkg::word_t  out_remainder_word0,
  output rm320_pkg::word_t  out_remainder_word1,
  output rm320_pkg::word_t  out_remainder_word2,
  output rm320_pkg::word_t  out_remainder_word3,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  rm320_pkg::cfg_idx_t cfg_index,
  input  rm320_pkg::word_t  cfg_data
);
  import rm320_pkg::*;

  word_t    modulus_r [NUM_MOD_WORDS];
  modulus_t modulus;
  value_t   div_base;
  logic     pipe_en;
  modulus_t result;

  logic   stg_valid [NUM_STEPS+1];
  value_t stg_value [NUM_STEPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOD_WORDS; i++) begin
        modulus_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODULUS_WORD0: modulus_r[0] <= cfg_data;
        CFG_MODULUS_WORD1: modulus_r[1] <= cfg_data;
        CFG_MODULUS_WORD2: modulus_r[2] <= cfg_data;
        CFG_MODULUS_WORD3: modulus_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign modulus  = {modulus_r[3], modulus_r[2], modulus_r[1], modulus_r[0]};
  assign div_base = {modulus, {REDUCTION_SHIFT{1'b0}}};

  assign stg_valid[0] = in_valid;
  assign stg_value[0] = {in_value_word4, in_value_word3, in_value_word2,
                         in_value_word1, in_value_word0};

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    value_t divisor;
    assign divisor = div_base >> k;

    rm320_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (stg_valid[k]),
      .in_value  (stg_value[k]),
      .divisor   (divisor),
      .out_valid (stg_valid[k+1]),
      .out_value (stg_value[k+1])
    );
  end

  rm320_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_valid (stg_valid[NUM_STEPS]),
    .tail_data  (stg_value[NUM_STEPS][MOD_W-1:0]),
    .pipe_en    (pipe_en),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (result)
  );

  assign in_stall = !pipe_en;

  assign out_remainder_word0 = result[WORD_W-1:0];
  assign out_remainder_word1 = result[2*WORD_W-1:WORD_W];
  assign out_remainder_word2 = result[3*WORD_W-1:2*WORD_W];
  assign out_remainder_word3 = result[4*WORD_W-1:3*WORD_W];

`ifndef SYNTH
  a_in_stall_only_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_cfg_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index == CFG_MODULUS_WORD0 |=> modulus_r[0] == $past(cfg_data))
    else $error("modulus word0 write lost");

  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input stall held after output drained");
`endif

endmodule
